@@ design/spq_pkg.sv @@
// shared types and constants of the stable priority queue
package spq_pkg;

    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 8;
    localparam int COUNT_OUT_W = 8;

    localparam logic [CFG_W-1:0] CAP_RESET = 8'd100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_CLR = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

@@ design/spq_cell.sv @@
// one slot of the sorted shift chain: holds an item and its priority
module spq_cell #(
    parameter int ITEM_BITS = 8,
    parameter int PRIO_BITS = 16
) (
    input  logic                        i_clk,
    input  spq_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_occ,
    input  logic [ITEM_BITS-1:0]        i_new_item,
    input  logic signed [PRIO_BITS-1:0] i_new_prio,
    input  logic                        i_left_shift,
    input  logic [ITEM_BITS-1:0]        i_left_item,
    input  logic signed [PRIO_BITS-1:0] i_left_prio,
    input  logic [ITEM_BITS-1:0]        i_right_item,
    input  logic signed [PRIO_BITS-1:0] i_right_prio,
    output logic                        o_shift,
    output logic [ITEM_BITS-1:0]        o_item,
    output logic signed [PRIO_BITS-1:0] o_prio,
    output logic [ITEM_BITS-1:0]        o_n_item,
    output logic signed [PRIO_BITS-1:0] o_n_prio
);

    logic [ITEM_BITS-1:0]        r_item;
    logic signed [PRIO_BITS-1:0] r_prio;
    logic [ITEM_BITS-1:0]        n_item;
    logic signed [PRIO_BITS-1:0] n_prio;

    // this slot is at or behind the insert point; equal priorities stay ahead
    assign o_shift = !(i_occ && (r_prio <= i_new_prio));

    always_comb begin
        n_item = r_item;
        n_prio = r_prio;
        if (i_ctl.enq) begin
            if (o_shift) begin
                if (i_left_shift) begin
                    n_item = i_left_item;
                    n_prio = i_left_prio;
                end else begin
                    n_item = i_new_item;
                    n_prio = i_new_prio;
                end
            end
        end else if (i_ctl.deq) begin
            n_item = i_right_item;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_prio <= n_prio;
    end

    assign o_item   = r_item;
    assign o_prio   = r_prio;
    assign o_n_item = n_item;
    assign o_n_prio = n_prio;

endmodule

@@ design/stable_priority_queue.sv @@
// top level of the stable priority queue: cell chain, count, capacity and result register
//
// Bounded priority queue of (item, priority) pairs kept sorted in a chain of
// MAX_ENTRIES cells; cell 0 is the front. Lower priority numbers leave first,
// equal priorities leave in arrival order.
// Input beat: tuser carries the operation (enqueue, dequeue, clear), tdata the
// item and its signed priority. Every input beat yields exactly one result beat
// with status, removed item, head item and priority, count, empty and full.
// Each operation is done in the cycle its beat is accepted: all cells compare
// their priority against the new one in parallel and shift one slot left or
// right; the result is registered and shows on the output in the cycle after
// acceptance; a new beat can be taken every cycle (one item per clock) while
// the receiver keeps up. The result register frees up in the same cycle the
// receiver takes it; while the receiver stalls with a result pending,
// o_s_tready is low and the chain holds its contents.
// Capacity is a register written through i_cfg_we / i_cfg_wdata, saturated at
// MAX_ENTRIES; write it only while no beat is in flight.
// Reset (synchronous, active low) empties the queue, sets capacity to 100 and
// drops o_m_tvalid; the cell contents are not cleared and need no clearing.
module stable_priority_queue #(
    parameter int MAX_ENTRIES = 128,
    parameter int ITEM_BITS   = 8,
    parameter int PRIO_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [spq_pkg::CFG_W-1:0]            i_cfg_wdata,  // capacity
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // item, priority_req
    input  logic [((ITEM_BITS+PRIO_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic [spq_pkg::FUNC_W-1:0]           i_s_tuser,    // func
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // out_item, head_item, head_priority, stored_count, empty_flag, full_flag
    output logic [((2*ITEM_BITS+PRIO_BITS+spq_pkg::COUNT_OUT_W+2+7)/8)*8-1:0] o_m_tdata,
    output logic [spq_pkg::STATUS_W-1:0]         o_m_tuser     // status
);

    localparam int OUT_F  = 2 * ITEM_BITS + PRIO_BITS + spq_pkg::COUNT_OUT_W + 2;
    localparam int OUT_W  = ((OUT_F + 7) / 8) * 8;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int WW     = (CW > spq_pkg::CFG_W) ? CW : spq_pkg::CFG_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_ENTRIES);

    logic                      r_m_valid;
    logic [OUT_W-1:0]          r_m_tdata;
    logic [spq_pkg::STATUS_W-1:0] r_m_tuser;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [spq_pkg::CFG_W-1:0] r_capacity;

    logic                        accept;
    spq_pkg::t_func              func;
    spq_pkg::t_status            status;
    spq_pkg::t_cell_ctl          ctl;
    logic [ITEM_BITS-1:0]        new_item;
    logic signed [PRIO_BITS-1:0] new_prio;
    logic [WW-1:0]               cap_w;
    logic [WW-1:0]               eff_cap;
    logic [WW-1:0]               count_w;
    logic [WW-1:0]               n_count_w;
    logic                        is_full;
    logic                        is_empty;
    logic [ITEM_BITS-1:0]        removed;
    logic [ITEM_BITS-1:0]        head_item;
    logic signed [PRIO_BITS-1:0] head_prio;
    logic [OUT_W-1:0]            n_m_tdata;

    logic [MAX_ENTRIES-1:0]      occ;
    logic [MAX_ENTRIES-1:0]      shift;
    logic [ITEM_BITS-1:0]        c_item   [MAX_ENTRIES];
    logic signed [PRIO_BITS-1:0] c_prio   [MAX_ENTRIES];
    logic [ITEM_BITS-1:0]        c_n_item [MAX_ENTRIES];
    logic signed [PRIO_BITS-1:0] c_n_prio [MAX_ENTRIES];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign func       = spq_pkg::t_func'(i_s_tuser);
    assign new_item   = i_s_tdata[ITEM_BITS-1:0];
    assign new_prio   = i_s_tdata[ITEM_BITS +: PRIO_BITS];

    assign cap_w    = WW'(r_capacity);
    assign eff_cap  = (cap_w > MAX_W) ? MAX_W : cap_w;
    assign count_w  = WW'(r_count);
    assign is_full  = count_w >= eff_cap;
    assign is_empty = (r_count == '0);

    always_comb begin
        status  = spq_pkg::ST_OK;
        ctl     = '0;
        n_count = r_count;
        removed = '0;
        if (accept) begin
            unique case (func)
                spq_pkg::FUNC_ENQ: begin
                    if (is_full) begin
                        status = spq_pkg::ST_FULL;
                    end else begin
                        ctl.enq = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                spq_pkg::FUNC_DEQ: begin
                    if (is_empty) begin
                        status = spq_pkg::ST_EMPTY;
                    end else begin
                        ctl.deq = 1'b1;
                        n_count = r_count - CW'(1);
                        removed = c_item[0];
                    end
                end
                spq_pkg::FUNC_CLR: begin
                    n_count = '0;
                end
                default: begin
                    // unused code: report the current state
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            logic                        left_shift;
            logic [ITEM_BITS-1:0]        left_item;
            logic signed [PRIO_BITS-1:0] left_prio;
            logic [ITEM_BITS-1:0]        right_item;
            logic signed [PRIO_BITS-1:0] right_prio;

            assign occ[gi] = CW'(gi) < r_count;

            if (gi == 0) begin : g_first
                assign left_shift = 1'b0;
                assign left_item  = new_item;
                assign left_prio  = new_prio;
            end else begin : g_mid
                assign left_shift = shift[gi-1];
                assign left_item  = c_item[gi-1];
                assign left_prio  = c_prio[gi-1];
            end

            if (gi == MAX_ENTRIES - 1) begin : g_last
                // nothing behind the last slot; its contents go past the count
                assign right_item = c_item[gi];
                assign right_prio = c_prio[gi];
            end else begin : g_inner
                assign right_item = c_item[gi+1];
                assign right_prio = c_prio[gi+1];
            end

            spq_cell #(
                .ITEM_BITS (ITEM_BITS),
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occ        (occ[gi]),
                .i_new_item   (new_item),
                .i_new_prio   (new_prio),
                .i_left_shift (left_shift),
                .i_left_item  (left_item),
                .i_left_prio  (left_prio),
                .i_right_item (right_item),
                .i_right_prio (right_prio),
                .o_shift      (shift[gi]),
                .o_item       (c_item[gi]),
                .o_prio       (c_prio[gi]),
                .o_n_item     (c_n_item[gi]),
                .o_n_prio     (c_n_prio[gi])
            );
        end
    endgenerate

    // result describes the queue after the operation
    assign n_count_w = WW'(n_count);
    assign head_item = (n_count != '0) ? c_n_item[0] : '0;
    assign head_prio = (n_count != '0) ? c_n_prio[0] : '0;

    always_comb begin
        n_m_tdata = '0;
        n_m_tdata[OUT_F-1:0] = {n_count_w >= eff_cap,
                                n_count == '0,
                                n_count_w[spq_pkg::COUNT_OUT_W-1:0],
                                head_prio,
                                head_item,
                                removed};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= spq_pkg::CAP_RESET;
            r_m_valid  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

@@ design/spq_checker.sv @@
// port-level checks of the stable priority queue, bound to the top level
module spq_checker #(
    parameter int ITEM_BITS = 8,
    parameter int PRIO_BITS = 16,
    parameter int OUT_W     = 48
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [OUT_W-1:0]              o_m_tdata,
    input logic [spq_pkg::STATUS_W-1:0]  o_m_tuser
);

    localparam int CNT_LO = 2 * ITEM_BITS + PRIO_BITS;
    localparam int EMP_B  = CNT_LO + spq_pkg::COUNT_OUT_W;
    localparam int FUL_B  = EMP_B + 1;

    logic [spq_pkg::COUNT_OUT_W-1:0] cnt;
    logic                            emp;
    logic                            ful;
    logic [ITEM_BITS-1:0]            out_item;

    assign cnt      = o_m_tdata[CNT_LO +: spq_pkg::COUNT_OUT_W];
    assign emp      = o_m_tdata[EMP_B];
    assign ful      = o_m_tdata[FUL_B];
    assign out_item = o_m_tdata[ITEM_BITS-1:0];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == spq_pkg::ST_FULL |-> ful && out_item == '0)
        else $error("full rejection without full flag");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == spq_pkg::ST_EMPTY |-> emp && cnt == '0 && out_item == '0)
        else $error("empty rejection with entries held");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> emp == (cnt == '0))
        else $error("empty flag disagrees with count");

endmodule

bind stable_priority_queue spq_checker #(
    .ITEM_BITS (ITEM_BITS),
    .PRIO_BITS (PRIO_BITS),
    .OUT_W     (OUT_W)
) u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
